@@ src/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

  // Parser phases, one per part of a frame.
  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5,
    PH_LEGACY  = 3'd6
  } phase_e;

  // Header and legacy framing codes.
  localparam logic [6:0] Len16Code    = 7'h7e;
  localparam logic [6:0] Len64Code    = 7'h7f;
  localparam logic [7:0] LegacyStart  = 8'h00;
  localparam logic [7:0] LegacyEnd    = 8'hff;

  // Depth of the result queue; it must hold at least two results.
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       message_end;
    logic       empty_message;
  } result_t;

  // Results of one step: count, then up to two items in order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ src/websocket_frame_deframer_core.sv @@
`timescale 1ns / 1ps

// WebSocket frame deframer.
// Received bytes enter on the s_axis channel, with tlast on the last byte of
// each chunk; a chunk carries at most one frame. Unmasked payload bytes leave
// on the m_axis channel, with tlast on the last result of a message and tuser
// set for a message with no payload bytes.
// The cfg channel writes the legacy framing enable; cfg_ready_o is always high.
// A transferred byte is held in the input register, parsed from there into
// the result queue, and its results are transferred out of the queue.
// Throughput is one byte per cycle while the receiver keeps up; a legacy chunk
// end may give two results, which the four-entry result queue absorbs.
// The parser steps only while the queue has two free entries. When the
// receiver stalls, the queue fills, the input register holds its byte and
// s_axis_tready falls; no result is lost.
// Reset clears the parser state, the queue and the legacy enable.
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,     // legacy_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // chunk_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // message_end
  output logic       m_axis_tuser    // [0] empty_message
);

  logic       legacy_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_ce_q;
  logic       room;
  logic       fire;
  logic       in_xfer;
  push_t      push;
  result_t    res;

  assign cfg_ready_o = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      legacy_q <= 1'b0;
    end else if (cfg_valid_i) begin
      legacy_q <= cfg_data_i;
    end
  end

  // Input register: refilled in the same cycle that its byte is parsed.
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_ce_q   <= s_axis_tlast;
    end
  end

  wsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .byte_i        (in_byte_q),
    .chunk_end_i   (in_ce_q),
    .legacy_mode_i (legacy_q),
    .push_o        (push)
  );

  wsd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire ? push : '0),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = res.out_byte;
  assign m_axis_tlast = res.message_end;
  assign m_axis_tuser = res.empty_message;

endmodule

@@ src/wsd_parser.sv @@
`timescale 1ns / 1ps

module wsd_parser import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       chunk_end_i,
  input  logic       legacy_mode_i,
  output push_t      push_o
);

  phase_e      phase_q, phase_d;
  logic        final_q, final_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [2:0]  ext_q, ext_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kpos_q, kpos_d;
  logic [7:0]  held_q, held_d;
  logic        held_valid_q, held_valid_d;
  push_t       push;

  // State registers, updated only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR1;
      final_q      <= 1'b0;
      masked_q     <= 1'b0;
      rem_q        <= '0;
      ext_q        <= '0;
      key_q        <= '0;
      kpos_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      final_q      <= final_d;
      masked_q     <= masked_d;
      rem_q        <= rem_d;
      ext_q        <= ext_d;
      key_q        <= key_d;
      kpos_q       <= kpos_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

  // One step of the deframer for the current byte.
  always_comb begin
    logic       len_done;
    logic       start;
    logic       last;
    logic       pending;
    logic [7:0] key_byte;
    logic [7:0] v;
    phase_d      = phase_q;
    final_d      = final_q;
    masked_d     = masked_q;
    rem_d        = rem_q;
    ext_d        = ext_q;
    key_d        = key_q;
    kpos_d       = kpos_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    push         = '0;
    len_done     = 1'b0;
    start        = 1'b0;
    last         = 1'b0;
    pending      = 1'b0;
    v            = byte_i;

    case (kpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    case (phase_q)
      PH_HDR2: begin
        masked_d = byte_i[7];
        if (byte_i[6:0] == Len16Code) begin
          rem_d   = '0;
          ext_d   = 3'd1;
          phase_d = PH_EXT;
        end else if (byte_i[6:0] == Len64Code) begin
          rem_d   = '0;
          ext_d   = 3'd7;
          phase_d = PH_EXT;
        end else begin
          rem_d    = {57'd0, byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        rem_d = {rem_q[55:0], byte_i};
        if (ext_q == 3'd0) begin
          len_done = 1'b1;
        end else begin
          ext_d = ext_q - 3'd1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], byte_i};
        if (kpos_q == 2'd3) begin
          start = 1'b1;
        end else begin
          kpos_d = kpos_q + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        if (masked_q) begin
          v = byte_i ^ key_byte;
        end
        kpos_d   = kpos_q + 2'd1;
        rem_d    = rem_q - 64'd1;
        last     = (rem_d == 64'd0) || chunk_end_i;
        push.cnt = 2'd1;
        push.r0  = '{out_byte: v, message_end: last, empty_message: 1'b0};
        if (last) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
      end
      PH_LEGACY: begin
        if (chunk_end_i) begin
          if (held_valid_q) begin
            push.cnt = 2'd1;
            push.r0  = '{out_byte: held_q, message_end: (byte_i == LegacyEnd),
                         empty_message: 1'b0};
          end
          if (byte_i != LegacyEnd) begin
            if (held_valid_q) begin
              push.r1 = '{out_byte: byte_i, message_end: 1'b1, empty_message: 1'b0};
            end else begin
              push.r0 = '{out_byte: byte_i, message_end: 1'b1, empty_message: 1'b0};
            end
            push.cnt = push.cnt + 2'd1;
          end
          if (push.cnt == 2'd0) begin
            push.cnt = 2'd1;
            push.r0  = '{out_byte: 8'd0, message_end: 1'b1, empty_message: 1'b1};
          end
          held_valid_d = 1'b0;
          phase_d      = PH_HDR1;
        end else begin
          if (held_valid_q) begin
            push.cnt = 2'd1;
            push.r0  = '{out_byte: held_q, message_end: 1'b0, empty_message: 1'b0};
          end
          held_d       = byte_i;
          held_valid_d = 1'b1;
        end
      end
      default: begin
        if (legacy_mode_i && (byte_i == LegacyStart)) begin
          held_valid_d = 1'b0;
          phase_d      = PH_LEGACY;
        end else begin
          final_d = byte_i[7];
          phase_d = byte_i[7] ? PH_HDR2 : PH_SKIP;
        end
      end
    endcase

    // Length complete: read the key if the frame is masked.
    if (len_done) begin
      if (masked_d) begin
        kpos_d  = '0;
        key_d   = '0;
        phase_d = PH_KEY;
      end else begin
        start = 1'b1;
      end
    end

    // Header complete: a zero length gives an empty message at once.
    if (start) begin
      kpos_d = '0;
      if (rem_d == 64'd0) begin
        push.cnt = 2'd1;
        push.r0  = '{out_byte: 8'd0, message_end: 1'b1, empty_message: 1'b1};
        phase_d  = PH_SKIP;
      end else begin
        phase_d = PH_PAYLOAD;
      end
    end

    // Chunk end closes any open message and restarts the parser.
    if (chunk_end_i) begin
      pending = (phase_d == PH_LEGACY) ||
                (final_d && (phase_d inside {PH_HDR2, PH_EXT, PH_KEY, PH_PAYLOAD}));
      if (pending && (push.cnt == 2'd0)) begin
        push.cnt = 2'd1;
        push.r0  = '{out_byte: 8'd0, message_end: 1'b1, empty_message: 1'b1};
      end
      phase_d      = PH_HDR1;
      held_valid_d = 1'b0;
    end
  end

  assign push_o = push;

  // Two results come only from a legacy chunk end.
  a_two_only_legacy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (push.cnt == 2'd2)) |-> (phase_q == PH_LEGACY && chunk_end_i))
    else $error("two results outside a legacy chunk end");

  // After a chunk end the parser waits for a first header byte.
  a_chunk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && chunk_end_i) |=> (phase_q == PH_HDR1 && !held_valid_q))
    else $error("parser not restarted after chunk end");

endmodule

@@ src/wsd_out_fifo.sv @@
`timescale 1ns / 1ps

module wsd_out_fifo import wsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t              mem_q [OutDepth];
  logic [OutPtrW-1:0]   wptr_q, wptr_d;
  logic [OutPtrW-1:0]   rptr_q, rptr_d;
  logic [OutPtrW:0]     count_q, count_d;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  // Room for the worst case of two results from one step.
  assign room_o  = (count_q <= (OutPtrW+1)'(OutDepth - 2));

  // Pointer and fill count updates.
  always_comb begin
    wptr_d  = wptr_q + OutPtrW'(push_i.cnt);
    rptr_d  = pop ? rptr_q + OutPtrW'(1) : rptr_q;
    count_d = count_q + (OutPtrW+1)'(push_i.cnt) - (OutPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Result storage; the second result goes to the following entry.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_q + OutPtrW'(1)] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (count_q <= (OutPtrW+1)'(OutDepth - 2)))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (OutPtrW+1)'(OutDepth))
    else $error("result queue count out of range");

endmodule
